### hw/rtl/bde_pkg.sv
package bde_pkg;

  // Window and source count of the sample store.
  localparam int WINDOW  = 10;
  localparam int SOURCES = 4;

  // Field widths.
  localparam int SRC_W      = 2;
  localparam int LEVEL_W    = 14;
  localparam int TS_W       = 32;
  localparam int RATE_W     = 28;
  localparam int THR_W      = 27;
  localparam int TIME_W     = 32;
  localparam int PROD_W     = 2 * LEVEL_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = THR_W;

  // Store geometry.
  localparam int SLOT_W    = $clog2(WINDOW);
  localparam int CNT_W     = $clog2(WINDOW + 1);
  localparam int MEM_DEPTH = SOURCES * WINDOW;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int ENTRY_W   = LEVEL_W + TS_W;

  // Stream packing.
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_HIGH_BIT  = SRC_W + RATE_W;
  localparam int OUT_VALID_BIT = SRC_W + RATE_W + 1;

  // Arithmetic constants.
  localparam logic [LEVEL_W-1:0] SCALE      = 14'd10000;
  localparam logic [RATE_W-1:0]  RATE_LIMIT = 28'd100000000;

  // Reset values of the registers.
  localparam logic [THR_W-1:0]   THR_RESET  = 27'd1500;
  localparam logic [LEVEL_W-1:0] CRIT_RESET = 14'd2000;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DRAIN_WARN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL   = 1'b1;

  // What the shared divider is working on.
  localparam logic [1:0] PH_RATE = 2'd0;
  localparam logic [1:0] PH_TTC  = 2'd1;
  localparam logic [1:0] PH_TTE  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [PROD_W-1:0] dividend;
    logic [TS_W-1:0]   divisor;
  } bde_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } bde_div_rsp_t;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } bde_mem_req_t;

  typedef struct packed {
    logic [SRC_W-1:0]  source_echo;
    logic [RATE_W-1:0] drop_rate;
    logic              rate_alarm;
    logic              estimate_valid;
    logic [TIME_W-1:0] time_to_critical_ms;
    logic [TIME_W-1:0] time_to_empty_ms;
  } bde_result_t;

endpackage

### hw/rtl/battery_drain_estimator.sv
// Battery drain estimator.
// Samples arrive on the s_axis channel: a source index, a level in 0.01 %
// units and a millisecond timestamp. Each sample gives one result on the
// m_axis channel: the drain rate in milli-percent per second over the last
// WINDOW samples of that source, a high drain flag, and, while the rate is
// positive, the times to the critical level and to empty in milliseconds.
// The cfg channel writes the warning threshold (index 0) and the critical
// level (index 1); it is always ready and should be used while idle.
// A sample with fewer than two stored samples or no time gap skips the
// divisions. Up to three divisions run one after another on a single
// restoring divider that yields one quotient bit per cycle, each with its
// own set-up; s_axis_tready is low throughout.
// Results sit in an output register. When the receiver stalls, the next
// sample is still taken and worked on, and its result waits until the
// register has been emptied.
// Reset clears the fill count and ring pointer of every source and loads
// the register defaults; stored samples need no clearing, as only written
// entries are ever used.
module battery_drain_estimator
  import bde_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // source_id[1:0], battery_level[15:2], timestamp_ms[47:16]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // source_echo[1:0], drop_rate[29:2], rate_alarm[30], estimate_valid[31],
  // time_to_critical_ms[63:32], time_to_empty_ms[95:64]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [THR_W-1:0]   thr;
  logic [LEVEL_W-1:0] crit;

  bde_mem_req_t       mem_req;
  logic [ENTRY_W-1:0] mem_rdata;
  bde_div_req_t       div_req;
  bde_div_rsp_t       div_rsp;
  logic               out_free;
  logic               res_load;
  bde_result_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr  <= THR_RESET;
      crit <= CRIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRAIN_WARN: thr  <= cfg_data[THR_W-1:0];
        CFG_CRITICAL:   crit <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  bde_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_src    (s_axis_tdata[SRC_W-1:0]),
    .in_level  (s_axis_tdata[SRC_W+LEVEL_W-1:SRC_W]),
    .in_ts     (s_axis_tdata[SRC_W+LEVEL_W+TS_W-1:SRC_W+LEVEL_W]),
    .thr       (thr),
    .crit      (crit),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res)
  );

  bde_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  bde_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Output register; it frees up in the same cycle as its transfer.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_axis_tdata <= {res.time_to_empty_ms, res.time_to_critical_ms, res.estimate_valid,
                       res.rate_alarm, res.drop_rate, res.source_echo};
    end
  end

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again straight after a transfer");

  a_div_no_restart: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while still running");

  a_high_implies_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[OUT_HIGH_BIT] |-> m_axis_tdata[OUT_VALID_BIT])
    else $error("high drain flagged without a positive rate");

endmodule

### hw/rtl/bde_mem.sv
module bde_mem
  import bde_pkg::*;
(
  input  logic               clk,
  input  bde_mem_req_t       req,
  output logic [ENTRY_W-1:0] rdata
);

  logic [ENTRY_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

### hw/rtl/bde_div.sv
module bde_div
  import bde_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  bde_div_req_t req,
  output bde_div_rsp_t rsp
);

  localparam int STEP_W = $clog2(PROD_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(PROD_W - 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [TS_W-1:0]   rem;
  logic [TS_W-1:0]   dvs;
  logic [PROD_W-1:0] dvd;
  logic [TS_W:0]     trial;
  logic [TS_W:0]     diff;
  logic              ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, dvd[PROD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      dvs <= req.divisor;
      dvd <= req.dividend;
    end else if (busy) begin
      rem <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
      dvd <= {dvd[PROD_W-2:0], ge};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = dvd;

endmodule

### hw/rtl/bde_seq.sv
module bde_seq
  import bde_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SRC_W-1:0]   in_src,
  input  logic [LEVEL_W-1:0] in_level,
  input  logic [TS_W-1:0]    in_ts,
  input  logic [THR_W-1:0]   thr,
  input  logic [LEVEL_W-1:0] crit,
  output bde_mem_req_t       mem_req,
  input  logic [ENTRY_W-1:0] mem_rdata,
  output bde_div_req_t       div_req,
  input  bde_div_rsp_t       div_rsp,
  input  logic               out_free,
  output logic               res_load,
  output bde_result_t        res
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WRITE = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_MUL   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_WAIT  = 4'd5;
  localparam logic [3:0] S_EST   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  localparam logic [SLOT_W:0] WIN_EXT  = (SLOT_W + 1)'(WINDOW);
  localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] TWO = CNT_W'(2);

  logic [3:0]         state;
  logic [SRC_W-1:0]   src;
  logic [LEVEL_W-1:0] lvl;
  logic [TS_W-1:0]    ts;
  logic [CNT_W-1:0]   fill_now;
  logic [LEVEL_W-1:0] mul_op;
  logic [PROD_W-1:0]  prod;
  logic [TS_W-1:0]    dt;
  logic               neg;
  logic [1:0]         phase;
  logic [RATE_W-1:0]  rate;
  logic               high;
  logic               valid;
  logic [TIME_W-1:0]  ttc;
  logic [TIME_W-1:0]  tte;

  logic [CNT_W-1:0]  fill_cnt [SOURCES];
  logic [SLOT_W-1:0] old_slot [SOURCES];

  logic              src_ok;
  logic [CNT_W-1:0]  fill_cur;
  logic [SLOT_W-1:0] old_cur;
  logic [SLOT_W:0]   slot_sum;
  logic [SLOT_W-1:0] wr_slot;
  logic [SLOT_W-1:0] old_next;
  logic [CNT_W-1:0]  fill_next;
  logic              full;

  logic [LEVEL_W-1:0] old_level;
  logic [TS_W-1:0]    old_ts;
  logic [TS_W-1:0]    dt_now;
  logic [LEVEL_W:0]   ldiff;
  logic [LEVEL_W-1:0] lmag;

  logic [PROD_W-1:0] q;
  logic [RATE_W-1:0] rate_sat;
  logic              rate_pos;

  function automatic logic [ADDR_W-1:0] entry_addr(input logic [SRC_W-1:0] s,
                                                   input logic [SLOT_W-1:0] sl);
    entry_addr = ADDR_W'(32'(s) * 32'(WINDOW) + 32'(sl));
  endfunction

  assign src_ok   = (32'(src) < 32'(SOURCES));
  assign fill_cur = fill_cnt[src];
  assign old_cur  = old_slot[src];
  assign full     = (fill_cur == WIN_CNT);

  // The new sample goes after the stored ones, or over the oldest once the ring is full.
  assign slot_sum  = {1'b0, old_cur} + {1'b0, fill_cur[SLOT_W-1:0]};
  assign wr_slot   = full ? old_cur
                   : ((slot_sum >= WIN_EXT) ? SLOT_W'(slot_sum - WIN_EXT) : slot_sum[SLOT_W-1:0]);
  assign old_next  = full ? ((old_cur == LAST_SLOT) ? '0 : old_cur + 1'b1) : old_cur;
  assign fill_next = full ? fill_cur : fill_cur + 1'b1;

  always_comb begin
    mem_req.we    = (state == S_WRITE) && src_ok;
    mem_req.waddr = entry_addr(src, wr_slot);
    mem_req.wdata = {ts, lvl};
    mem_req.re    = (state == S_WRITE) && src_ok;
    mem_req.raddr = entry_addr(src, old_next);
  end

  // Oldest entry against the newest, which is the sample in hand.
  assign old_level = mem_rdata[LEVEL_W-1:0];
  assign old_ts    = mem_rdata[ENTRY_W-1:LEVEL_W];
  assign dt_now    = ts - old_ts;
  assign ldiff     = {1'b0, old_level} - {1'b0, lvl};
  assign lmag      = ldiff[LEVEL_W] ? LEVEL_W'(-ldiff) : ldiff[LEVEL_W-1:0];

  assign q        = div_rsp.quotient;
  assign rate_sat = (q > RATE_LIMIT) ? RATE_LIMIT : q;
  assign rate_pos = !rate[RATE_W-1] && (rate != '0);

  always_comb begin
    div_req.start    = (state == S_DIV);
    div_req.dividend = prod;
    div_req.divisor  = (phase == PH_RATE) ? dt : {{(TS_W - RATE_W){1'b0}}, rate};
  end

  assign in_ready = (state == S_IDLE);
  assign res_load = (state == S_OUT) && out_free;

  always_comb begin
    res.source_echo         = src;
    res.drop_rate           = rate;
    res.rate_alarm          = high;
    res.estimate_valid      = valid;
    res.time_to_critical_ms = ttc;
    res.time_to_empty_ms    = tte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      for (int i = 0; i < SOURCES; i++) begin
        fill_cnt[i] <= '0;
        old_slot[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (src_ok) begin
            fill_cnt[src] <= fill_next;
            old_slot[src] <= old_next;
            state         <= S_READ;
          end else begin
            state <= S_EST;
          end
        end
        S_READ: begin
          if (fill_now < TWO || dt_now == '0) begin
            state <= S_EST;
          end else begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV;
        end
        S_DIV: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            case (phase)
              PH_RATE: state <= S_EST;
              PH_TTC:  state <= S_MUL;
              default: state <= S_OUT;
            endcase
          end
        end
        S_EST: begin
          state <= rate_pos ? S_MUL : S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        src  <= in_src;
        lvl  <= in_level;
        ts   <= in_ts;
        rate <= '0;
      end
      S_WRITE: begin
        fill_now <= fill_next;
      end
      S_READ: begin
        dt     <= dt_now;
        neg    <= ldiff[LEVEL_W];
        mul_op <= lmag;
        phase  <= PH_RATE;
      end
      S_MUL: begin
        prod <= {{LEVEL_W{1'b0}}, mul_op} * {{LEVEL_W{1'b0}}, SCALE};
      end
      S_WAIT: begin
        if (div_rsp.done) begin
          case (phase)
            PH_RATE: begin
              rate <= neg ? -rate_sat : rate_sat;
            end
            PH_TTC: begin
              ttc    <= TIME_W'(q);
              mul_op <= lvl;
              phase  <= PH_TTE;
            end
            default: begin
              tte <= TIME_W'(q);
            end
          endcase
        end
      end
      S_EST: begin
        high <= $signed(rate) > $signed({1'b0, thr});
        valid <= rate_pos;
        ttc   <= '0;
        tte   <= '0;
        if (lvl > crit) begin
          mul_op <= lvl - crit;
          phase  <= PH_TTC;
        end else begin
          mul_op <= lvl;
          phase  <= PH_TTE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
